@@ rtl/sird_pkg.sv @@
// ----------------------------------------------------------------------------
// sird_pkg
// Shared types, constants and helper functions for the radix digit printer.
// ----------------------------------------------------------------------------
package sird_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int MAG_W       = 32;
    localparam int BYTE_IDX_W  = 2;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_W     = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = STORE_W + 1;
    localparam int TABLE_W     = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
    localparam logic [TABLE_W-1:0] CHARS_LO_RESET = 64'h3736_3534_3332_3130;
    localparam logic [TABLE_W-1:0] CHARS_HI_RESET = 64'h6665_6463_6261_3938;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HI = 2'd2;

    typedef struct packed {
        logic             invalid;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sird_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sird_qstat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT,
        ST_BAD
    } sird_state_t;

    function automatic logic [CHAR_W-1:0] char_of_digit(
        input logic [TABLE_W-1:0] lo,
        input logic [TABLE_W-1:0] hi,
        input logic [DIGIT_W-1:0] k
    );
        logic [2*TABLE_W-1:0] tbl;
        tbl = {hi, lo};
        return tbl[{k, 3'b000} +: CHAR_W];
    endfunction

    // Flags a radix outside 2 to 16, or a used entry that is zero, a plus or a minus sign, or equal to another.
    function automatic logic table_bad(
        input logic [RADIX_W-1:0] radix,
        input logic [TABLE_W-1:0] lo,
        input logic [TABLE_W-1:0] hi
    );
        logic              bad;
        logic [CHAR_W-1:0] ci;
        bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            ci = char_of_digit(lo, hi, DIGIT_W'(i));
            if (RADIX_W'(i) < radix) begin
                if (ci == '0 || ci == CHAR_PLUS || ci == CHAR_MINUS) begin
                    bad = 1'b1;
                end
                for (int m = i + 1; m < MAX_RADIX; m++) begin
                    if (RADIX_W'(m) < radix && char_of_digit(lo, hi, DIGIT_W'(m)) == ci) begin
                        bad = 1'b1;
                    end
                end
            end
        end
        return bad;
    endfunction

    // Index of the most significant non-zero byte; zero for a zero value.
    function automatic logic [BYTE_IDX_W-1:0] top_byte(input logic [MAG_W-1:0] v);
        logic [BYTE_IDX_W-1:0] idx;
        if (v[31:24] != '0) begin
            idx = 2'd3;
        end
        else if (v[23:16] != '0) begin
            idx = 2'd2;
        end
        else if (v[15:8] != '0) begin
            idx = 2'd1;
        end
        else begin
            idx = 2'd0;
        end
        return idx;
    endfunction

endpackage

@@ rtl/sird_front.sv @@
// ----------------------------------------------------------------------------
// sird_front
// Accepts input values, takes the magnitude and sign, checks the digit table
// and queues one job per value.
// ----------------------------------------------------------------------------
module sird_front (
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sird_pkg::MAG_W-1:0]   number,
    input  logic        [sird_pkg::RADIX_W-1:0] radix,
    input  logic        [sird_pkg::TABLE_W-1:0] chars_lo,
    input  logic        [sird_pkg::TABLE_W-1:0] chars_hi,
    input  sird_pkg::sird_qstat_t               qstat,
    output logic                                push,
    output sird_pkg::sird_job_t                 job
);
    import sird_pkg::*;

    logic [MAG_W-1:0] raw;

    assign raw      = unsigned'(number);
    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

    // The most negative value wraps to 2^31, which is its correct unsigned magnitude.
    assign job.neg     = raw[MAG_W-1];
    assign job.mag     = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
    assign job.invalid = table_bad(radix, chars_lo, chars_hi);

endmodule

@@ rtl/sird_fifo.sv @@
// ----------------------------------------------------------------------------
// sird_fifo
// Short job queue between the front end and the conversion engine.
// ----------------------------------------------------------------------------
module sird_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sird_pkg::sird_job_t   push_job,
    input  logic                  pop,
    output sird_pkg::sird_job_t   head,
    output sird_pkg::sird_qstat_t qstat
);
    import sird_pkg::*;

    sird_job_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue holds more entries than its depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("job taken from an empty queue");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill level did not follow a lone push");
`endif

endmodule

@@ rtl/sird_back.sv @@
// ----------------------------------------------------------------------------
// sird_back
// Conversion engine: repeated division by the radix, eight dividend bits per cycle, digits
// kept in a small store, then any minus sign and the digits, most significant first.
// ----------------------------------------------------------------------------
module sird_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sird_pkg::sird_qstat_t               qstat,
    input  sird_pkg::sird_job_t                 head,
    output logic                                pop,
    input  logic        [sird_pkg::RADIX_W-1:0] radix,
    input  logic        [sird_pkg::TABLE_W-1:0] chars_lo,
    input  logic        [sird_pkg::TABLE_W-1:0] chars_hi,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic        [sird_pkg::CHAR_W-1:0]  char_code,
    output logic                                invalid_base,
    output logic                                last
);
    import sird_pkg::*;

    sird_state_t           state_reg;
    sird_state_t           state_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [COUNT_W-1:0]    idx_reg;
    logic [COUNT_W-1:0]    idx_next;
    logic [COUNT_W-1:0]    idx_m1;
    logic [COUNT_W-1:0]    rd_idx;
    logic [STORE_W-1:0]    rd_addr;
    logic [BYTE_IDX_W-1:0] byte_reg;
    logic [BYTE_IDX_W-1:0] byte_next;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      mag_next;
    logic [MAG_W-1:0]      quo_reg;
    logic [MAG_W-1:0]      quo_next;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [DIGIT_W-1:0]    rem_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [DIGIT_W-1:0]    digit_store_reg [STORE_DEPTH];
    logic [DIGIT_W-1:0]    digit_rd_reg;
    logic                  store_we;

    logic [RADIX_W-1:0]    rem;
    logic [7:0]            qbyte;
    logic [7:0]            cur_byte;
    logic [MAG_W-1:0]      q_full;
    logic                  out_free;

    logic                  load;
    logic [CHAR_W-1:0]     load_char;
    logic                  load_bad;
    logic                  load_last;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CHAR_W-1:0]     char_code_reg;
    logic                  invalid_base_reg;
    logic                  last_reg;

    assign idx_m1   = idx_reg - 1'b1;
    assign out_free = !out_valid_reg || !out_stall;
    assign cur_byte = mag_reg[{byte_reg, 3'b000} +: 8];

    // The store is read through a register, at the digit that the next index points to.
    assign rd_idx  = idx_next - 1'b1;
    assign rd_addr = rd_idx[STORE_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        mag_next   = mag_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        pop        = 1'b0;
        store_we   = 1'b0;
        load       = 1'b0;
        load_char  = '0;
        load_bad   = 1'b0;
        load_last  = 1'b0;

        // Restoring division of one dividend byte; the remainder stays below the radix.
        rem   = {1'b0, rem_reg};
        qbyte = '0;
        for (int b = 7; b >= 0; b--) begin
            rem = {rem[DIGIT_W-1:0], cur_byte[b]};
            if (rem >= radix) begin
                rem      = rem - radix;
                qbyte[b] = 1'b1;
            end
        end
        q_full = quo_reg | (MAG_W'(qbyte) << {byte_reg, 3'b000});

        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty) begin
                    pop = 1'b1;
                    if (head.invalid) begin
                        state_next = ST_BAD;
                    end
                    else begin
                        mag_next   = head.mag;
                        neg_next   = head.neg;
                        count_next = '0;
                        quo_next   = '0;
                        rem_next   = '0;
                        byte_next  = top_byte(head.mag);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                quo_next = q_full;
                rem_next = rem[DIGIT_W-1:0];
                if (byte_reg == '0) begin
                    // Lowest byte done: the remainder is the next digit.
                    store_we   = 1'b1;
                    count_next = count_reg + 1'b1;
                    mag_next   = q_full;
                    quo_next   = '0;
                    rem_next   = '0;
                    byte_next  = top_byte(q_full);
                    if (q_full == '0 || count_reg == COUNT_W'(STORE_DEPTH - 1)) begin
                        idx_next   = count_reg + 1'b1;
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
                else begin
                    byte_next = byte_reg - 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (out_free) begin
                    load       = 1'b1;
                    load_char  = CHAR_MINUS;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free) begin
                    load      = 1'b1;
                    load_char = char_of_digit(chars_lo, chars_hi, digit_rd_reg);
                    load_last = (idx_reg == COUNT_W'(1));
                    idx_next  = idx_m1;
                    if (idx_reg == COUNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAD:
            begin
                if (out_free) begin
                    load       = 1'b1;
                    load_bad   = 1'b1;
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            byte_reg      <= '0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            byte_reg      <= byte_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (store_we) begin
            digit_store_reg[count_reg[STORE_W-1:0]] <= rem[DIGIT_W-1:0];
        end
        // The most significant digit is written as it is first read.
        if (store_we && rd_addr == count_reg[STORE_W-1:0]) begin
            digit_rd_reg <= rem[DIGIT_W-1:0];
        end
        else begin
            digit_rd_reg <= digit_store_reg[rd_addr];
        end
        if (load) begin
            char_code_reg    <= load_char;
            invalid_base_reg <= load_bad;
            last_reg         <= load_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign char_code    = char_code_reg;
    assign invalid_base = invalid_base_reg;
    assign last         = last_reg;

`ifndef SYNTH
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && !qstat.empty))
        else $error("job taken while the engine was busy");
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && invalid_base_reg) |-> last_reg)
        else $error("invalid table beat not marked as the final one");
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (idx_reg != '0 && idx_reg <= count_reg))
        else $error("digit index outside the digits produced");
    a_div_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && byte_reg == '0 &&
         count_reg == COUNT_W'(STORE_DEPTH - 1)) |=> state_reg != ST_DIV)
        else $error("division ran past the digit store");
`endif

endmodule

@@ rtl/signed_integer_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Prints a signed 32-bit value as text in a configured radix, using a
// configured table of digit characters, sign first and most significant first.
// ----------------------------------------------------------------------------
// Conversion: each digit is found by the shared byte-wide divide step, one
// significant byte of the remaining magnitude (1 to 4) at a time from the top,
// then each character takes one output beat.
// Throughput: one value at a time in the engine; a two-entry job queue lets
// the input side take further values meanwhile.
// Reset: the radix returns to 10, the table to "0123456789abcdef", the queue
// empties and no output beat is pending.
module signed_integer_to_radix_digits (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [sird_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [sird_pkg::TABLE_W-1:0]   cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [sird_pkg::MAG_W-1:0]     number,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [sird_pkg::CHAR_W-1:0]    char_code,
    output logic                                  invalid_base,
    output logic                                  last
);
    import sird_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [TABLE_W-1:0] chars_lo_reg;
    logic [TABLE_W-1:0] chars_hi_reg;

    logic               push;
    logic               pop;
    sird_job_t          push_job;
    sird_job_t          head;
    sird_qstat_t        qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg    <= RADIX_RESET;
            chars_lo_reg <= CHARS_LO_RESET;
            chars_hi_reg <= CHARS_HI_RESET;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_RADIX:    radix_reg    <= cfg_data[RADIX_W-1:0];
                CFG_CHARS_LO: chars_lo_reg <= cfg_data;
                CFG_CHARS_HI: chars_hi_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    sird_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .number   (number),
        .radix    (radix_reg),
        .chars_lo (chars_lo_reg),
        .chars_hi (chars_hi_reg),
        .qstat    (qstat),
        .push     (push),
        .job      (push_job)
    );

    sird_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    sird_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .head         (head),
        .pop          (pop),
        .radix        (radix_reg),
        .chars_lo     (chars_lo_reg),
        .chars_hi     (chars_hi_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_code    (char_code),
        .invalid_base (invalid_base),
        .last         (last)
    );

endmodule

@@ verif/signed_integer_to_radix_digits_tb.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_tb
// Self-checking bench for the radix digit printer. Every accepted value is
// converted by a local predictor under the current radix and digit table,
// and each output beat is compared with the oldest predicted character.
// Directed values cover the extremes, every radix boundary and each kind of
// bad table; random tables and values follow, with bursty input, random
// output stalls and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_tb;
    import sird_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              bad;
        logic              fin;
    } text_beat_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_RADIX;
    logic [TABLE_W-1:0]   cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic signed [31:0]   number       = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [CHAR_W-1:0]    char_code;
    logic                 invalid_base;
    logic                 last;

    // Local copy of the configuration as last written.
    logic [RADIX_W-1:0]   cur_radix;
    logic [TABLE_W-1:0]   cur_lo;
    logic [TABLE_W-1:0]   cur_hi;

    text_beat_t           expected_text[$];
    text_beat_t           head_beat;
    int                   errors       = 0;
    int                   cycle_count  = 0;
    int                   burst_left   = 0;
    int                   max_gap      = 4;
    bit                   long_hold_req = 1'b0;
    bit                   hold_taken   = 1'b0;
    int                   hold_left    = 0;
    int                   seg_left     = 0;
    int                   stall_pct    = 0;

    signed_integer_to_radix_digits DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .number       (number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_code    (char_code),
        .invalid_base (invalid_base),
        .last         (last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] table_char(input int k);
        if (k < 8)
            return cur_lo[8*k +: 8];
        return cur_hi[8*(k-8) +: 8];
    endfunction

    function automatic logic table_rejected();
        logic [CHAR_W-1:0] ci;
        if (cur_radix < 2 || cur_radix > MAX_RADIX)
            return 1'b1;
        for (int i = 0; i < cur_radix; i++)
        begin
            ci = table_char(i);
            if (ci == 8'h00 || ci == CHAR_PLUS || ci == CHAR_MINUS)
                return 1'b1;
            for (int m = i + 1; m < cur_radix; m++)
                if (table_char(m) == ci)
                    return 1'b1;
        end
        return 1'b0;
    endfunction

    // Queues the characters that one value prints to, sign first.
    function automatic void predict_text(input logic [31:0] value);
        logic [31:0]        mag;
        logic [DIGIT_W-1:0] digits [32];
        int                 count;
        text_beat_t         b;
        if (table_rejected())
        begin
            b = '{8'h00, 1'b1, 1'b1};
            expected_text.push_back(b);
            return;
        end
        mag = value[31] ? -value : value;
        count = 0;
        do
        begin
            digits[count] = DIGIT_W'(mag % 32'(cur_radix));
            mag = mag / 32'(cur_radix);
            count++;
        end while (mag != 0 && count < 32);
        if (value[31])
        begin
            b = '{CHAR_MINUS, 1'b0, 1'b0};
            expected_text.push_back(b);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            b = '{table_char(digits[i]), 1'b0, (i == 0)};
            expected_text.push_back(b);
        end
    endfunction

    // Distinct legal characters for the used digits; unused entries are noise.
    function automatic logic [127:0] random_table(input int used);
        logic [127:0]      tbl;
        logic [CHAR_W-1:0] c;
        bit                clash;
        tbl = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < used; i++)
        begin
            do
            begin
                c = $urandom_range(255, 0);
                clash = (c == 8'h00 || c == CHAR_PLUS || c == CHAR_MINUS);
                for (int j = 0; j < i; j++)
                    if (tbl[8*j +: 8] == c)
                        clash = 1'b1;
            end while (clash);
            tbl[8*i +: 8] = c;
        end
        return tbl;
    endfunction

    function automatic logic [31:0] random_number();
        logic [31:0] v;
        logic [63:0] p;
        int          base;
        int          steps;
        case ($urandom_range(5, 0))
            0, 1: v = $urandom;
            2: v = $urandom_range(40, 0);
            3:
            begin
                base = (cur_radix < 2 || cur_radix > MAX_RADIX) ? 2 : cur_radix;
                steps = $urandom_range(31, 0);
                p = 1;
                for (int i = 0; i < steps; i++)
                    if (p * base < 64'h1_0000_0000)
                        p = p * base;
                v = p[31:0] - $urandom_range(1, 0);
            end
            4:
            begin
                case ($urandom_range(4, 0))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h0000_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: v = $urandom >> $urandom_range(31, 0);
        endcase
        if ($urandom_range(1, 0) == 1 && v != 32'h8000_0000)
            v = -v;
        return v;
    endfunction

    // Output stall: segments of random density, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (long_hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(150, 10);
                case ($urandom_range(3, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected beat: char_code %h invalid_base %b last %b",
                       char_code, invalid_base, last);
                errors++;
            end
            else
            begin
                head_beat = expected_text.pop_front();
                if (char_code !== head_beat.code)
                begin
                    $error("char_code: expected %h, got %h", head_beat.code, char_code);
                    errors++;
                end
                if (invalid_base !== head_beat.bad)
                begin
                    $error("invalid_base: expected %b, got %b", head_beat.bad,
                           invalid_base);
                    errors++;
                end
                if (last !== head_beat.fin)
                begin
                    $error("last: expected %b, got %b", head_beat.fin, last);
                    errors++;
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with valid possibly
    // still high for the next beat of the burst.
    task automatic send_number(input logic [31:0] value);
        in_valid <= 1'b1;
        number <= value;
        do
            @(posedge clk);
        while (in_stall);
        predict_text(value);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else if (max_gap > 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(max_gap, 1)) @(negedge clk);
            burst_left = $urandom_range(12, 0);
        end
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes all three registers; only called while the block is idle.
    task automatic load_table(input logic [RADIX_W-1:0] r, input logic [TABLE_W-1:0] lo,
                              input logic [TABLE_W-1:0] hi);
        logic [TABLE_W-1:0] word;
        word = {$urandom, $urandom};
        word[RADIX_W-1:0] = r;
        cfg_we <= 1'b1;
        cfg_index <= CFG_RADIX;
        cfg_data <= word;
        @(negedge clk);
        cfg_index <= CFG_CHARS_LO;
        cfg_data <= lo;
        @(negedge clk);
        cfg_index <= CFG_CHARS_HI;
        cfg_data <= hi;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_radix = r;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic test_default_table();
        send_number(32'd0);
        send_number(32'd9);
        send_number(32'd10);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        wait_until_idle();
    endtask

    task automatic test_radix_extremes();
        load_table(5'd2, 64'hFFFF_FFFF_FFFF_807F, 64'h0000_0000_0000_0000);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'd0);
        wait_until_idle();
        load_table(5'd16, 64'h8001_FE7F_5A41_30FF, 64'h2A2C_2E3D_C3E0_1122);
        send_number(32'h8000_0000);
        send_number(32'hFFFF_FFFF);
        send_number(32'hDEAD_BEEF);
        wait_until_idle();
    endtask

    task automatic test_bad_tables();
        logic [TABLE_W-1:0] dec_lo;
        logic [TABLE_W-1:0] dec_hi;
        logic [TABLE_W-1:0] t;
        dec_lo = 64'h3736_3534_3332_3130;
        dec_hi = 64'h6665_6463_6261_3938;
        load_table(5'd0, dec_lo, dec_hi);
        send_number(32'd5);
        wait_until_idle();
        load_table(5'd1, dec_lo, dec_hi);
        send_number(32'hFFFF_FFF0);
        wait_until_idle();
        load_table(5'd17, dec_lo, dec_hi);
        send_number(32'd123);
        wait_until_idle();
        load_table(5'd31, dec_lo, dec_hi);
        send_number(32'h8000_0000);
        wait_until_idle();
        // A plus sign among the used digits.
        t = dec_lo;
        t[8*3 +: 8] = CHAR_PLUS;
        load_table(5'd10, t, dec_hi);
        send_number(32'd42);
        wait_until_idle();
        // A minus sign on the highest used digit.
        t = dec_hi;
        t[8*1 +: 8] = CHAR_MINUS;
        load_table(5'd10, dec_lo, t);
        send_number(32'd42);
        wait_until_idle();
        t = dec_lo;
        t[7:0] = 8'h00;
        load_table(5'd10, t, dec_hi);
        send_number(32'd0);
        wait_until_idle();
        // The first and the last used digit share a character.
        t = dec_hi;
        t[15:8] = dec_lo[7:0];
        load_table(5'd10, dec_lo, t);
        send_number(32'd99);
        wait_until_idle();
        // Bad characters beyond the radix are of no concern.
        load_table(5'd4, 64'h2B2D_0033_3332_3130, 64'h3130_002D_2B00_3332);
        send_number(-32'sd123456);
        wait_until_idle();
    endtask

    task automatic test_random_tables();
        logic [127:0]       tbl;
        logic [RADIX_W-1:0] r;
        int                 k1;
        int                 k2;
        int                 items;
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: r = 5'd2;
                1: r = 5'd16;
                2: r = 5'd3;
                default: r = $urandom_range(16, 2);
            endcase
            tbl = random_table(r);
            items = 31;
            if (phase % 5 == 4)
            begin
                items = 10;
                k1 = $urandom_range(r - 1, 0);
                case ($urandom_range(3, 0))
                    0: r = $urandom_range(1, 0) ? $urandom_range(1, 0) : $urandom_range(31, 17);
                    1: tbl[8*k1 +: 8] = 8'h00;
                    2: tbl[8*k1 +: 8] = $urandom_range(1, 0) ? CHAR_PLUS : CHAR_MINUS;
                    default:
                    begin
                        do
                            k2 = $urandom_range(r - 1, 0);
                        while (k2 == k1);
                        tbl[8*k2 +: 8] = tbl[8*k1 +: 8];
                    end
                endcase
            end
            load_table(r, tbl[63:0], tbl[127:64]);
            case ($urandom_range(3, 0))
                0: max_gap = 0;
                1: max_gap = 2;
                2: max_gap = 6;
                default: max_gap = 15;
            endcase
            for (int n = 0; n < items; n++)
                send_number(random_number());
            wait_until_idle();
        end
    endtask

    // Holds the output off long enough for the job queue to fill behind it.
    task automatic test_output_hold();
        logic [127:0] tbl;
        tbl = random_table(2);
        load_table(5'd2, tbl[63:0], tbl[127:64]);
        max_gap = 0;
        long_hold_req = 1'b1;
        for (int n = 0; n < 24; n++)
            send_number(random_number());
        wait_until_idle();
    endtask

    initial
    begin
        cur_radix = 5'd10;
        cur_lo = 64'h3736_3534_3332_3130;
        cur_hi = 64'h6665_6463_6261_3938;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_table();
        test_radix_extremes();
        test_bad_tables();
        test_random_tables();
        test_output_hold();
        repeat (60) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            $error("%0d expected beats never arrived", expected_text.size());
            errors++;
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
